/* sv/mfu_pkg.sv */
// Package for the material fatigue update block: payload structs, fixed-point
// constants, pipeline latencies and saturating add/subtract helpers.
// Has no dependencies; every other file in sv/ refers to it by scoped names.
package mfu_pkg;

  localparam int FRAC = 32;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [32:0] ONE = 33'(64'd1 << FRAC);
  localparam logic [63:0] HUNDREDTH = 64'(((64'd1 << FRAC) + 64'd50) / 64'd100);
  localparam logic [32:0] TENTH = 33'(((64'd1 << FRAC) + 64'd5) / 64'd10);

  localparam int LAT_MUL = 3;
  localparam int LAT_SQRT = 49;
  localparam int LAT_DIV = 98;

  localparam int DIV_BITS = 96;
  localparam int SQRT_STEPS = 48;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TOUGHNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;

  typedef struct packed {
    logic signed [63:0] principal_stress_1;
    logic signed [63:0] principal_stress_2;
    logic signed [63:0] principal_stress_3;
    logic [62:0]        fatigue_in;
    logic signed [63:0] yield_in;
  } in_t;

  typedef struct packed {
    logic [32:0]        integrity;
    logic [62:0]        fatigue_out;
    logic signed [63:0] yield_out;
    logic               failed;
  } out_t;

  function automatic logic [63:0] mag(input logic [63:0] a);
    return a[63] ? 64'(-a) : a;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

endpackage

/* sv/material_fatigue_update.sv */
// Material fatigue update: von Mises stress, fatigue damage, integrity and
// yield softening. One element can be taken every cycle; a stalled result holds
// the whole pipeline. The latency is set by the two dividers and the square root.
// Synchronous active-low reset clears all valid bits and sets toughness to 1.0
// and time_step to 0. Uses mfu_pkg, mfu_mul, mfu_div and mfu_sqrt.
module material_fatigue_update (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mfu_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mfu_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int T_D = 1;
  localparam int T_SQ = T_D + mfu_pkg::LAT_MUL;
  localparam int T_H = T_SQ + 1;
  localparam int T_EQ = T_H + mfu_pkg::LAT_SQRT;
  localparam int T_E = T_EQ + 1;
  localparam int T_YM = T_E + mfu_pkg::LAT_MUL;
  localparam int T_YN = T_YM + 1;
  localparam int T_RAT = T_EQ + mfu_pkg::LAT_DIV;
  localparam int T_R2 = T_RAT + mfu_pkg::LAT_MUL;
  localparam int T_DMG = T_R2 + mfu_pkg::LAT_MUL;
  localparam int T_DT = T_DMG + mfu_pkg::LAT_MUL;
  localparam int T_FAT = T_DT + 1;
  localparam int T_LOSS = T_FAT + mfu_pkg::LAT_DIV;

  localparam int NA = T_EQ;
  localparam int NF = T_DT;
  localparam int NB = mfu_pkg::LAT_MUL;
  localparam int NC = T_LOSS - T_YN;
  localparam int ND = mfu_pkg::LAT_MUL;
  localparam int NG = mfu_pkg::LAT_DIV;

  logic        en;
  logic [62:0] toughness_r, time_step_r;
  logic [63:0] d1_r, d2_r, d3_r;
  logic [63:0] sq1, sq2, sq3, sum;
  logic [62:0] h_r;
  logic [47:0] root;
  logic [63:0] eq;
  logic [T_LOSS-1:0] v_r;

  logic [127:0] dla_r [NA];
  logic [62:0]  dlf_r [NF];
  logic [64:0]  dlb_r [NB];
  logic [63:0]  dlc_r [NC];
  logic [63:0]  dld_r [ND];
  logic [62:0]  dlg_r [NG];

  logic [63:0] yld_a, dv_a;
  logic [63:0] e_r, yld_e_r, ym, yn_r;
  logic        gt_r;
  logic [63:0] rat, r2, dmg, dt, fat_sum;
  logic [62:0] fat_r;
  logic [63:0] loss;
  logic [32:0] integ;
  logic        out_valid_r;
  mfu_pkg::out_t out_data_r;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toughness_r <= 63'(64'd1 << mfu_pkg::FRAC);
      time_step_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mfu_pkg::REG_TOUGHNESS: toughness_r <= cfg_data[62:0];
        mfu_pkg::REG_TIME_STEP: time_step_r <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[T_LOSS-2:0], in_valid};
      out_valid_r <= v_r[T_LOSS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= mfu_pkg::sat_sub(in_data.principal_stress_1, in_data.principal_stress_2);
      d2_r <= mfu_pkg::sat_sub(in_data.principal_stress_2, in_data.principal_stress_3);
      d3_r <= mfu_pkg::sat_sub(in_data.principal_stress_3, in_data.principal_stress_1);
      dla_r[0] <= {in_data.yield_in, mfu_pkg::sat_add(in_data.yield_in, 64'd1)};
      dlf_r[0] <= in_data.fatigue_in;
      for (int i = 1; i < NA; i++) dla_r[i] <= dla_r[i-1];
      for (int i = 1; i < NF; i++) dlf_r[i] <= dlf_r[i-1];
      h_r <= sum[63:1];
      e_r <= mfu_pkg::sat_sub(eq, yld_a);
      gt_r <= $signed(eq) > $signed(yld_a);
      yld_e_r <= yld_a;
      dlb_r[0] <= {gt_r, yld_e_r};
      for (int i = 1; i < NB; i++) dlb_r[i] <= dlb_r[i-1];
      yn_r <= dlb_r[NB-1][64] ? mfu_pkg::sat_sub(dlb_r[NB-1][63:0], ym)
                              : dlb_r[NB-1][63:0];
      dlc_r[0] <= yn_r;
      for (int i = 1; i < NC; i++) dlc_r[i] <= dlc_r[i-1];
      dld_r[0] <= rat;
      for (int i = 1; i < ND; i++) dld_r[i] <= dld_r[i-1];
      fat_r <= fat_sum[63] ? 63'd0 : fat_sum[62:0];
      dlg_r[0] <= fat_r;
      for (int i = 1; i < NG; i++) dlg_r[i] <= dlg_r[i-1];
      out_data_r <= '{integrity: integ, fatigue_out: dlg_r[NG-1], yield_out: dlc_r[NC-1],
                      failed: (integ < mfu_pkg::TENTH)};
    end
  end

  assign sum = mfu_pkg::sat_add(mfu_pkg::sat_add(sq1, sq2), sq3);
  assign eq = {16'd0, root};
  assign yld_a = dla_r[NA-1][127:64];
  assign dv_a = dla_r[NA-1][63:0];
  assign fat_sum = mfu_pkg::sat_add({1'b0, dlf_r[NF-1]}, dt);
  assign integ = (loss < 64'(mfu_pkg::ONE)) ? (mfu_pkg::ONE - loss[32:0]) : 33'd0;

  mfu_mul u_sq1 (.clk(clk), .en(en), .a(d1_r), .b(d1_r), .p(sq1));
  mfu_mul u_sq2 (.clk(clk), .en(en), .a(d2_r), .b(d2_r), .p(sq2));
  mfu_mul u_sq3 (.clk(clk), .en(en), .a(d3_r), .b(d3_r), .p(sq3));

  mfu_sqrt u_sqrt (.clk(clk), .en(en), .h(h_r), .root(root));

  mfu_mul u_soft (.clk(clk), .en(en), .a(e_r), .b(mfu_pkg::HUNDREDTH), .p(ym));

  mfu_div u_ratio (
    .clk(clk), .en(en), .num(eq), .den(mfu_pkg::mag(dv_a)), .neg(dv_a[63]), .q(rat)
  );

  mfu_mul u_r2  (.clk(clk), .en(en), .a(rat), .b(rat), .p(r2));
  mfu_mul u_dmg (.clk(clk), .en(en), .a(r2), .b(dld_r[ND-1]), .p(dmg));
  mfu_mul u_dt  (.clk(clk), .en(en), .a(dmg), .b({1'b0, time_step_r}), .p(dt));

  mfu_div u_loss (
    .clk(clk), .en(en), .num({1'b0, fat_r}), .den({1'b0, toughness_r}), .neg(1'b0), .q(loss)
  );

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

/* sv/mfu_mul.sv */
// Three-stage signed fixed-point multiplier: magnitudes, 32x32 partial
// products, then sum, truncating shift and saturation. Uses mfu_pkg.
module mfu_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0]  ma_r, mb_r;
  logic         neg1_r, neg2_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] full;
  logic [95:0]  s;
  logic [63:0]  p_nxt;
  logic [63:0]  p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= mfu_pkg::mag(a);
      mb_r <= mfu_pkg::mag(b);
      neg1_r <= a[63] ^ b[63];
      ll_r <= 64'(ma_r[31:0]) * 64'(mb_r[31:0]);
      lh_r <= 64'(ma_r[31:0]) * 64'(mb_r[63:32]);
      hl_r <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      hh_r <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
      neg2_r <= neg1_r;
      p_r <= p_nxt;
    end
  end

  always_comb begin
    full = {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {64'd0, ll_r};
    s = full[127:mfu_pkg::FRAC];
    if (neg2_r) begin
      p_nxt = (s > 96'(mfu_pkg::S64_MIN)) ? mfu_pkg::S64_MIN : 64'(-s[63:0]);
    end else begin
      p_nxt = (s > 96'(mfu_pkg::S64_MAX)) ? mfu_pkg::S64_MAX : s[63:0];
    end
  end

  assign p = p_r;

endmodule

/* sv/mfu_div.sv */
// Pipelined restoring fixed-point divider, one quotient bit per stage, with
// zero-divisor handling and signed saturation at the end. Uses mfu_pkg.
module mfu_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  logic        neg,
  output logic [63:0] q
);

  localparam int N = mfu_pkg::DIV_BITS;

  logic [N-1:0]  n_r [N+1];
  logic [N-1:0]  q_r [N+1];
  logic [63:0]   r_r [N+1];
  logic [63:0]   d_r [N+1];
  logic [N:0]    neg_r, dz_r, nz_r;
  logic [63:0]   q_nxt;
  logic [63:0]   q_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= {num, 32'd0};
      q_r[0] <= '0;
      r_r[0] <= '0;
      d_r[0] <= den;
      neg_r[0] <= neg;
      dz_r[0] <= (den == 64'd0);
      nz_r[0] <= (num != 64'd0);
      q_out_r <= q_nxt;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [64:0] rs;
    logic        ge;
    logic [64:0] diff;
    assign rs = {r_r[k], n_r[k][N-1]};
    assign ge = rs >= {1'b0, d_r[k]};
    assign diff = rs - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1] <= ge ? diff[63:0] : rs[63:0];
        q_r[k+1] <= {q_r[k][N-2:0], ge};
        n_r[k+1] <= {n_r[k][N-2:0], 1'b0};
        d_r[k+1] <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        dz_r[k+1] <= dz_r[k];
        nz_r[k+1] <= nz_r[k];
      end
    end
  end

  always_comb begin
    if (dz_r[N]) begin
      q_nxt = nz_r[N] ? mfu_pkg::S64_MAX : 64'd0;
    end else if (neg_r[N]) begin
      q_nxt = (q_r[N] > N'(mfu_pkg::S64_MIN)) ? mfu_pkg::S64_MIN : 64'(-q_r[N][63:0]);
    end else begin
      q_nxt = (q_r[N] > N'(mfu_pkg::S64_MAX)) ? mfu_pkg::S64_MAX : q_r[N][63:0];
    end
  end

  assign q = q_out_r;

endmodule

/* sv/mfu_sqrt.sv */
// Pipelined digit-by-digit square root of a Q32.32 value, one result bit per
// stage, truncating. Uses mfu_pkg.
module mfu_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] h,
  output logic [47:0] root
);

  localparam int S = mfu_pkg::SQRT_STEPS;

  logic [95:0] x_r    [S+1];
  logic [51:0] rem_r  [S+1];
  logic [47:0] root_r [S+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= {1'b0, h, 32'd0};
      rem_r[0] <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [51:0] rs;
    logic [51:0] trial;
    logic        ge;
    assign rs = {rem_r[k][49:0], x_r[k][95:94]};
    assign trial = {2'b00, root_r[k], 2'b01};
    assign ge = rs >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (rs - trial) : rs;
        root_r[k+1] <= {root_r[k][46:0], ge};
        x_r[k+1] <= {x_r[k][93:0], 2'b00};
      end
    end
  end

  assign root = root_r[S];

endmodule

/* sv/mfu_checker.sv */
// Port-level checker for material_fatigue_update, attached by bind.
// Uses mfu_pkg for the payload type and the fixed-point constants.
module mfu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input mfu_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed before transfer.");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow the output stall.");

  a_integ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.integrity <= mfu_pkg::ONE)
    else $error("Integrity exceeds one.");

  a_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.failed == (out_data.integrity < mfu_pkg::TENTH))
    else $error("Failed flag disagrees with integrity.");

endmodule

bind material_fatigue_update mfu_checker u_mfu_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_data(out_data)
);
